// ----- src/ultrasonic_echo_ranger_macros.svh -----
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger assertion macros
// Concurrent assertion wrappers on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_ECHO_RANGER_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define UER_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define UER_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define UER_ASSERT_IMP(name, ante, cons, msg)
`define UER_ASSERT_NXT(name, ante, cons, msg)
`endif

`endif

// ----- src/uer_pkg.sv -----
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger package
// Shared word types, register indexes, reset values and scaling constants.
// ----------------------------------------------------------------------------
package uer_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO_TIMEOUT_TICKS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_MIN_DIST     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_MAX_DIST     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_TICKS        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REST_TICKS         = 3'd5;

  localparam int WIDTH_W = 15;
  localparam int DIST_W  = 16;
  localparam int SCALE_W = 13;
  localparam int PROD_W  = WIDTH_W + SCALE_W;

  // Distance = width * 7025 >> 12 (0.01715 cm per tick in Q1.12)
  localparam logic [SCALE_W-1:0] DIST_SCALE = 13'd7025;
  localparam int                 DIST_SHIFT = 12;

  typedef struct packed {
    logic [7:0]         trigger_ticks;
    logic [WIDTH_W-1:0] echo_timeout_ticks;
    logic [DIST_W-1:0]  alarm_min_dist;
    logic [DIST_W-1:0]  alarm_max_dist;
    logic [17:0]        alarm_ticks;
    logic [17:0]        rest_ticks;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    trigger_ticks:      8'd10,
    echo_timeout_ticks: 15'd30000,
    alarm_min_dist:     16'd200,
    alarm_max_dist:     16'd3000,
    alarm_ticks:        18'd50000,
    rest_ticks:         18'd200000
  };

  typedef struct packed {
    logic              trigger_level;
    logic              alarm_level;
    logic              reading_ready;
    logic              timed_out;
    logic [DIST_W-1:0] distance;
  } res_t;

  // Unsaturated distance for an echo width
  function automatic logic [DIST_W-1:0] width_to_dist(input logic [WIDTH_W-1:0] width);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(width) * PROD_W'(DIST_SCALE);
    return prod[DIST_SHIFT +: DIST_W];
  endfunction

endpackage

// ----- src/uer_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger configuration registers
// Write-only register file loaded from the plain configuration port.
// ----------------------------------------------------------------------------
module uer_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [uer_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output uer_pkg::cfg_t                 cfg
);

  uer_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= uer_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        uer_pkg::CFG_TRIGGER_TICKS:      cfg_r.trigger_ticks      <= cfg_wdata[7:0];
        uer_pkg::CFG_ECHO_TIMEOUT_TICKS: cfg_r.echo_timeout_ticks <= cfg_wdata[14:0];
        uer_pkg::CFG_ALARM_MIN_DIST:     cfg_r.alarm_min_dist     <= cfg_wdata[15:0];
        uer_pkg::CFG_ALARM_MAX_DIST:     cfg_r.alarm_max_dist     <= cfg_wdata[15:0];
        uer_pkg::CFG_ALARM_TICKS:        cfg_r.alarm_ticks        <= cfg_wdata[17:0];
        uer_pkg::CFG_REST_TICKS:         cfg_r.rest_ticks         <= cfg_wdata[17:0];
        default: ; // drop writes to unused indexes
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- src/uer_fsm.sv -----
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger sequencer
// Phase state, tick counter and echo width; one result word per echo tick.
// ----------------------------------------------------------------------------
`include "ultrasonic_echo_ranger_macros.svh"

module uer_fsm #(
  parameter int COUNT_BITS = 18,
  parameter int DIST_BITS  = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  uer_pkg::cfg_t cfg,
  input  logic          acc,
  input  logic          echo,
  output uer_pkg::res_t res
);

  localparam int CW = (COUNT_BITS > 18) ? COUNT_BITS : 18;
  localparam int DW = uer_pkg::DIST_W;
  localparam logic [DW-1:0] DIST_LIM =
    (DIST_BITS >= DW) ? {DW{1'b1}} : DW'((64'd1 << DIST_BITS) - 64'd1);

  typedef enum logic [2:0] {
    PH_TRIG  = 3'd0,
    PH_WAIT  = 3'd1,
    PH_MEAS  = 3'd2,
    PH_ALARM = 3'd3,
    PH_REST  = 3'd4
  } phase_t;

  phase_t                        phase_r, phase_nxt, rest_phase;
  logic [COUNT_BITS-1:0]         cnt_r, cnt_nxt, cnt_inc;
  logic [uer_pkg::WIDTH_W-1:0]   width_r, width_nxt;
  logic [7:0]                    tlen;
  logic [DW-1:0]                 dist_raw, dist_sat;
  logic                          in_win;

  assign cnt_inc    = cnt_r + COUNT_BITS'(1);
  assign tlen       = (cfg.trigger_ticks == 8'd0) ? 8'd1 : cfg.trigger_ticks;
  assign rest_phase = (cfg.rest_ticks == 18'd0) ? PH_TRIG : PH_REST;
  assign dist_raw   = uer_pkg::width_to_dist(width_r);
  assign dist_sat   = (dist_raw > DIST_LIM) ? DIST_LIM : dist_raw;
  assign in_win     = (dist_sat > cfg.alarm_min_dist) && (dist_sat < cfg.alarm_max_dist);

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    width_nxt = width_r;
    res       = '0;
    unique case (phase_r)
      PH_TRIG: begin
        res.trigger_level = 1'b1;
        if (CW'(cnt_inc) >= CW'(tlen)) begin
          phase_nxt = PH_WAIT;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      PH_WAIT: begin
        if (echo) begin
          width_nxt = uer_pkg::WIDTH_W'(1);
          phase_nxt = PH_MEAS;
          cnt_nxt   = '0;
        end else if (CW'(cnt_r) >= CW'(cfg.echo_timeout_ticks)) begin
          res.reading_ready = 1'b1;
          res.timed_out     = 1'b1;
          width_nxt         = '0;
          cnt_nxt           = '0;
          phase_nxt         = rest_phase;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      PH_MEAS: begin
        if (echo) begin
          if (width_r >= cfg.echo_timeout_ticks) begin
            res.reading_ready = 1'b1;
            res.timed_out     = 1'b1;
            width_nxt         = '0;
            cnt_nxt           = '0;
            phase_nxt         = rest_phase;
          end else begin
            width_nxt = width_r + uer_pkg::WIDTH_W'(1);
          end
        end else begin
          res.reading_ready = 1'b1;
          res.distance      = dist_sat;
          width_nxt         = '0;
          cnt_nxt           = '0;
          if (in_win && (cfg.alarm_ticks != 18'd0)) begin
            phase_nxt = PH_ALARM;
          end else begin
            phase_nxt = rest_phase;
          end
        end
      end
      PH_ALARM: begin
        res.alarm_level = 1'b1;
        if (CW'(cnt_inc) >= CW'(cfg.alarm_ticks)) begin
          cnt_nxt   = '0;
          phase_nxt = rest_phase;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      PH_REST: begin
        if (CW'(cnt_inc) >= CW'(cfg.rest_ticks)) begin
          cnt_nxt   = '0;
          phase_nxt = PH_TRIG;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      default: begin
        // restart from trigger on an unused code
        phase_nxt = PH_TRIG;
        cnt_nxt   = '0;
        width_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TRIG;
      cnt_r   <= '0;
      width_r <= '0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      width_r <= width_nxt;
    end
  end

  `UER_ASSERT_NXT(a_hold_when_idle, !acc,
                  $stable(phase_r) && $stable(cnt_r) && $stable(width_r),
                  "sequencer state moved without an accepted word")
  `UER_ASSERT_NXT(a_meas_ends_on_fall, acc && (phase_r == PH_MEAS) && !echo,
                  (phase_r != PH_MEAS) && (width_r == '0),
                  "echo fall did not close the measurement")
  `UER_ASSERT_IMP(a_timeout_no_dist, acc && res.timed_out,
                  res.reading_ready && (res.distance == '0),
                  "timed-out reading carries a distance")

endmodule

// ----- src/uer_out_buf.sv -----
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger output buffer
// Result register plus one skid entry; frees the input side while stalled.
// ----------------------------------------------------------------------------
`include "ultrasonic_echo_ranger_macros.svh"

module uer_out_buf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  uer_pkg::res_t push_word,
  output logic          full,
  output logic          out_valid,
  input  logic          out_stall,
  output uer_pkg::res_t out_word
);

  logic          out_valid_r, skid_valid_r;
  uer_pkg::res_t out_word_r, skid_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      // output slot frees: skid first, else the new word
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      out_word_r <= skid_valid_r ? skid_word_r : push_word;
    end
    if (out_valid_r && out_stall && push) begin
      skid_word_r <= push_word;
    end
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `UER_ASSERT_IMP(a_skid_behind_out, skid_valid_r, out_valid_r,
                  "skid entry held while output register empty")
  `UER_ASSERT_NXT(a_skid_fills, out_valid_r && out_stall && push,
                  skid_valid_r, "word pushed into stalled buffer was dropped")
  `UER_ASSERT_NXT(a_skid_drains, skid_valid_r && !out_stall,
                  !skid_valid_r && out_valid_r, "skid entry not moved on release")

endmodule

// ----- src/ultrasonic_echo_ranger.sv -----
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger
// Trigger / echo timing controller for a pulse-echo ultrasonic range sensor.
// ----------------------------------------------------------------------------
// Feed one input word per microsecond tick carrying the sampled echo pin
// level; every accepted word yields exactly one result word carrying the
// trigger and alarm drive levels for that tick plus a reading_ready pulse,
// timed_out flag and distance (0.01 cm, width * 7025 >> 12, saturating).
// The block loops trigger -> wait for rise -> measure high width -> optional
// alarm -> optional rest. Throughput is one word per clock while in_stall is
// low: the phase/counter update and the 15x13 distance multiply with its
// window compare all complete in the cycle that the word is accepted, and the
// result is registered in the output register, or in the skid entry if that
// register is full and stalled. With one skid entry, in_stall rises only once
// both hold a word: in the cycle after out_stall blocks a full result register
// while a new word arrives. It falls again after the first edge with out_stall
// low. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger #(
  parameter int COUNT_BITS = 18,
  parameter int DIST_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // tick input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_echo_level,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_trigger_level,
  output logic                           out_alarm_level,
  output logic                           out_reading_ready,
  output logic                           out_timed_out,
  output logic [uer_pkg::DIST_W-1:0]     out_distance
);

  uer_pkg::cfg_t cfg;
  uer_pkg::res_t res_word;
  uer_pkg::res_t out_word;
  logic          buf_full;
  logic          in_acc;

  // Take a tick word whenever the skid entry is free.
  assign in_stall = buf_full;
  assign in_acc   = in_valid && !buf_full;

  uer_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Sequencer: advances only on an accepted tick, so stalls freeze time.
  uer_fsm #(
    .COUNT_BITS (COUNT_BITS),
    .DIST_BITS  (DIST_BITS)
  ) u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .acc   (in_acc),
    .echo  (in_echo_level),
    .res   (res_word)
  );

  uer_out_buf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc),
    .push_word (res_word),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // Unpack the result word onto its field ports.
  assign out_trigger_level = out_word.trigger_level;
  assign out_alarm_level   = out_word.alarm_level;
  assign out_reading_ready = out_word.reading_ready;
  assign out_timed_out     = out_word.timed_out;
  assign out_distance      = out_word.distance;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger testbench
// Drives one echo-level word per tick and checks every result word.
// ----------------------------------------------------------------------------
// A model of an echo sensor produces the ticks. It follows the tracked phase
// of the block: a pulse follows each trigger with a random delay and width,
// and some pulses are late or long enough to force a timeout. A little noise
// is mixed in. A short table of directed ticks and register writes comes
// first. Random register settings follow, including both extremes. Each
// result word is compared field by field against a tracking model of the
// ranger, or against the result typed into its directed table row.
// ----------------------------------------------------------------------------
module testbench;

  localparam int  STALL_LIMIT = 2000;        // cycles with no word moving
  localparam int  N_PHASES    = 10;          // register settings in the random part
  localparam int  DIST_MAX    = (1 << uer_pkg::DIST_W) - 1;

  // Ranger phases as tracked by the checker
  typedef enum logic [2:0] {
    PH_TRIGGER, PH_RISE_WAIT, PH_MEASURE, PH_ALARM, PH_REST
  } ranger_phase_t;

  // Directed table rows: a plain tick, a tick with its result typed in,
  // or a register write
  typedef enum logic [1:0] {ROW_TICK, ROW_TICK_CHK, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t                       kind;
    logic                            echo;
    logic [uer_pkg::CFG_IDX_W-1:0]   idx;
    logic [uer_pkg::CFG_DATA_W-1:0]  val;
    uer_pkg::res_t                   want;
  } dir_row_t;

  logic                           clk           = 1'b0;
  logic                           rst_n         = 1'b0;
  logic                           cfg_we        = 1'b0;
  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index     = uer_pkg::CFG_TRIGGER_TICKS;
  logic [uer_pkg::CFG_DATA_W-1:0] cfg_wdata     = '0;
  logic                           in_valid      = 1'b0;
  logic                           in_echo_level = 1'b0;
  logic                           out_stall     = 1'b0;
  logic                           in_stall;
  logic                           out_valid;
  logic                           out_trigger_level;
  logic                           out_alarm_level;
  logic                           out_reading_ready;
  logic                           out_timed_out;
  logic [uer_pkg::DIST_W-1:0]     out_distance;

  // Tracking model state and its copy of the registers
  uer_pkg::cfg_t                  live_cfg = uer_pkg::CFG_RESET;
  ranger_phase_t                  trk_phase = PH_TRIGGER;
  logic [17:0]                    trk_count = '0;
  logic [uer_pkg::WIDTH_W-1:0]    trk_width = '0;

  // Result words owed by the block, oldest first
  uer_pkg::res_t          pending_words [$];

  // Echo sensor model
  int                     echo_pos   = 0;
  int                     pulse_at   = 0;
  int                     pulse_len  = 1;
  int                     noise_pct  = 0;
  bit                     armed      = 1'b0;
  bit                     quiet      = 1'b0;
  bit                     reg_burst  = 1'b0;

  int                     errors       = 0;
  int                     ticks_sent   = 0;
  int                     settings     = 0;
  int                     readings     = 0;
  int                     timeouts     = 0;
  int                     alarm_seen   = 0;
  int                     idle_cycles  = 0;

  ultrasonic_echo_ranger DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_echo_level     (in_echo_level),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_trigger_level (out_trigger_level),
    .out_alarm_level   (out_alarm_level),
    .out_reading_ready (out_reading_ready),
    .out_timed_out     (out_timed_out),
    .out_distance      (out_distance)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Tracking model
  // --------------------------------------------------------------------------

  // Leave a result or an alarm: skip the rest phase when its length is zero
  task automatic enter_rest();
    trk_count = '0;
    trk_phase = (live_cfg.rest_ticks == '0) ? PH_TRIGGER : PH_REST;
  endtask

  // Advance the tracked ranger by one tick and return the word it owes
  task automatic advance_ranger(input logic echo, output uer_pkg::res_t r);
    logic [17:0]                 tlen;
    logic [31:0]                 prod;
    logic [uer_pkg::DIST_W-1:0]  dist_val;
    r = '0;
    case (trk_phase)
      PH_TRIGGER: begin
        r.trigger_level = 1'b1;
        // A zero trigger length still gives one trigger tick
        tlen = (live_cfg.trigger_ticks == '0) ? 18'd1 : 18'(live_cfg.trigger_ticks);
        trk_count = trk_count + 1'b1;
        if (trk_count >= tlen) begin
          trk_phase = PH_RISE_WAIT;
          trk_count = '0;
        end
      end
      PH_RISE_WAIT: begin
        if (echo) begin
          // The rising tick is the first tick of the width
          trk_width = uer_pkg::WIDTH_W'(1);
          trk_phase = PH_MEASURE;
          trk_count = '0;
        end else if (trk_count >= 18'(live_cfg.echo_timeout_ticks)) begin
          r.reading_ready = 1'b1;
          r.timed_out     = 1'b1;
          trk_width       = '0;
          enter_rest();
        end else begin
          trk_count = trk_count + 1'b1;
        end
      end
      PH_MEASURE: begin
        if (echo) begin
          if (trk_width >= live_cfg.echo_timeout_ticks) begin
            r.reading_ready = 1'b1;
            r.timed_out     = 1'b1;
            trk_width       = '0;
            enter_rest();
          end else begin
            trk_width = trk_width + 1'b1;
          end
        end else begin
          // Falling tick: scale the width to 0.01 cm, truncate and saturate
          prod = (32'(trk_width) * 32'(uer_pkg::DIST_SCALE)) >> uer_pkg::DIST_SHIFT;
          dist_val = (prod > 32'(DIST_MAX)) ? uer_pkg::DIST_W'(DIST_MAX)
                                            : prod[uer_pkg::DIST_W-1:0];
          r.reading_ready = 1'b1;
          r.distance      = dist_val;
          trk_width       = '0;
          // Alarm only strictly inside the window; a zero alarm length skips it
          if (dist_val > live_cfg.alarm_min_dist && dist_val < live_cfg.alarm_max_dist) begin
            trk_count = '0;
            if (live_cfg.alarm_ticks == '0) enter_rest();
            else trk_phase = PH_ALARM;
          end else begin
            enter_rest();
          end
        end
      end
      PH_ALARM: begin
        r.alarm_level = 1'b1;
        trk_count = trk_count + 1'b1;
        if (trk_count >= live_cfg.alarm_ticks) enter_rest();
      end
      PH_REST: begin
        trk_count = trk_count + 1'b1;
        if (trk_count >= live_cfg.rest_ticks) begin
          trk_phase = PH_TRIGGER;
          trk_count = '0;
        end
      end
      default: begin
        trk_phase = PH_TRIGGER;
        trk_count = '0;
        trk_width = '0;
      end
    endcase
    if (r.reading_ready) readings++;
    if (r.timed_out) timeouts++;
    if (r.alarm_level) alarm_seen++;
  endtask

  // --------------------------------------------------------------------------
  // Echo sensor model
  // --------------------------------------------------------------------------

  // Plan the pulse that answers the current trigger
  function automatic void plan_pulse();
    int tmo;
    int cap;
    int pick;
    tmo  = int'(live_cfg.echo_timeout_ticks);
    cap  = (tmo > 48) ? 48 : tmo;
    pick = $urandom_range(0, 99);
    pulse_at  = $urandom_range(0, cap);
    pulse_len = $urandom_range(1, (cap < 1) ? 1 : cap);
    if (pick < 12) pulse_at = tmo + 1 + $urandom_range(0, 3);        // late rise
    else if (pick < 24) pulse_len = tmo + 1 + $urandom_range(0, 3);  // long echo
  endfunction

  // Echo level for the next tick, given the phase that will take it
  function automatic logic next_echo();
    logic lvl;
    if (trk_phase == PH_TRIGGER) begin
      if (!armed) plan_pulse();
      armed    = 1'b1;
      echo_pos = 0;
      lvl      = 1'($urandom_range(0, 1));
    end else if (trk_phase == PH_RISE_WAIT || trk_phase == PH_MEASURE) begin
      armed = 1'b0;
      lvl   = (echo_pos >= pulse_at) && (echo_pos < pulse_at + pulse_len);
      echo_pos++;
      if ($urandom_range(0, 99) < noise_pct) lvl = ~lvl;
    end else begin
      // Ignored outside the measurement; toggle freely
      armed = 1'b0;
      lvl   = 1'($urandom_range(0, 1));
    end
    return lvl;
  endfunction

  // Random bits above a register's width, now and then
  function automatic logic [uer_pkg::CFG_DATA_W-1:0] with_junk(
      input logic [uer_pkg::CFG_DATA_W-1:0] v, input int w);
    logic [uer_pkg::CFG_DATA_W-1:0] hi;
    hi = uer_pkg::CFG_DATA_W'($urandom()) << w;
    return ($urandom_range(0, 3) == 0) ? (v | hi) : v;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offer one tick word and hold it until accepted, then owe its result.
  // With fixed set, the typed-in result is owed instead of the tracked one.
  task automatic send_tick(input logic echo, input bit fixed, input uer_pkg::res_t want);
    uer_pkg::res_t tracked;
    // Close a register burst before the next word
    if (reg_burst) begin
      cfg_we    <= 1'b0;
      reg_burst = 1'b0;
    end
    while (!quiet && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_echo_level <= echo;
    do @(posedge clk); while (in_stall);
    advance_ranger(echo, tracked);
    pending_words.push_back(fixed ? want : tracked);
    ticks_sent++;
  endtask

  // Write one register, only once every owed word has come back
  task automatic write_reg(input logic [uer_pkg::CFG_IDX_W-1:0] idx,
                           input logic [uer_pkg::CFG_DATA_W-1:0] val);
    if (!reg_burst) begin
      in_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clk);
      repeat (2) @(posedge clk);
      reg_burst = 1'b1;
      settings++;
    end
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    // Keep only the bits that the register holds
    case (idx)
      uer_pkg::CFG_TRIGGER_TICKS:
        live_cfg.trigger_ticks      = val[7:0];
      uer_pkg::CFG_ECHO_TIMEOUT_TICKS:
        live_cfg.echo_timeout_ticks = val[uer_pkg::WIDTH_W-1:0];
      uer_pkg::CFG_ALARM_MIN_DIST:
        live_cfg.alarm_min_dist     = val[uer_pkg::DIST_W-1:0];
      uer_pkg::CFG_ALARM_MAX_DIST:
        live_cfg.alarm_max_dist     = val[uer_pkg::DIST_W-1:0];
      uer_pkg::CFG_ALARM_TICKS:
        live_cfg.alarm_ticks        = val[17:0];
      uer_pkg::CFG_REST_TICKS:
        live_cfg.rest_ticks         = val[17:0];
      default: ;
    endcase
  endtask

  // Table row builders
  function automatic dir_row_t tick_row(input logic echo);
    dir_row_t row;
    row      = '0;
    row.kind = ROW_TICK;
    row.echo = echo;
    return row;
  endfunction

  // flags = {trigger, alarm, ready, timed_out}
  function automatic dir_row_t tick_chk(input logic echo, input logic [3:0] flags,
                                        input logic [uer_pkg::DIST_W-1:0] dist_val);
    dir_row_t row;
    row      = '0;
    row.kind = ROW_TICK_CHK;
    row.echo = echo;
    {row.want.trigger_level, row.want.alarm_level,
     row.want.reading_ready, row.want.timed_out} = flags;
    row.want.distance = dist_val;
    return row;
  endfunction

  function automatic dir_row_t reg_row(input logic [uer_pkg::CFG_IDX_W-1:0] idx,
                                       input logic [uer_pkg::CFG_DATA_W-1:0] val);
    dir_row_t row;
    row      = '0;
    row.kind = ROW_REG;
    row.idx  = idx;
    row.val  = val;
    return row;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t dir_rows [$];
    int       tmo;
    int       lo;

    dir_rows = '{
      // Out of reset: trigger phase, echo ignored
      tick_chk(1'b1, 4'b1000, '0),
      // Short trigger, timeout of three ticks, widest window, brief alarm and rest
      reg_row(uer_pkg::CFG_TRIGGER_TICKS,      18'd1),
      reg_row(uer_pkg::CFG_ECHO_TIMEOUT_TICKS, 18'd3),
      reg_row(uer_pkg::CFG_ALARM_MIN_DIST,     18'd0),
      reg_row(uer_pkg::CFG_ALARM_MAX_DIST,     18'd65535),
      reg_row(uer_pkg::CFG_ALARM_TICKS,        18'd2),
      reg_row(uer_pkg::CFG_REST_TICKS,         18'd1),
      tick_chk(1'b0, 4'b1000, '0),     // last trigger tick
      tick_row(1'b1),                  // rise: first width tick
      tick_chk(1'b0, 4'b0010, 16'd1),  // one-tick echo, in window
      tick_chk(1'b0, 4'b0100, '0),     // alarm
      tick_chk(1'b1, 4'b0100, '0),     // alarm, then rest
      tick_row(1'b0),                  // rest
      tick_row(1'b1),                  // trigger, echo ignored
      tick_row(1'b0),
      tick_row(1'b0),
      tick_row(1'b0),
      tick_chk(1'b0, 4'b0011, '0),     // no rise in time
      tick_row(1'b0),                  // rest
      // Zero trigger length, zero timeout, alarm and rest skipped
      reg_row(uer_pkg::CFG_TRIGGER_TICKS,      18'd0),
      reg_row(uer_pkg::CFG_ECHO_TIMEOUT_TICKS, 18'd0),
      reg_row(uer_pkg::CFG_ALARM_TICKS,        18'd0),
      reg_row(uer_pkg::CFG_REST_TICKS,         18'd0),
      tick_chk(1'b0, 4'b1000, '0),     // zero trigger acts as one tick
      tick_chk(1'b0, 4'b0011, '0),     // zero timeout: first low wait tick
      tick_row(1'b1),                  // trigger again, rest skipped
      tick_row(1'b1),                  // rise
      tick_chk(1'b0, 4'b0010, 16'd1),  // in window, no alarm ticks
      tick_row(1'b0),                  // trigger
      tick_row(1'b1),                  // rise
      tick_chk(1'b1, 4'b0011, '0)      // zero timeout: second high tick
    };

    // Hold reset low, then release it
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) write_reg(dir_rows[i].idx, dir_rows[i].val);
      else send_tick(dir_rows[i].echo, dir_rows[i].kind == ROW_TICK_CHK, dir_rows[i].want);
    end

    // Random part: one register setting per phase, sensor-shaped ticks
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin
          // Top of every range: long trigger, empty window, very long alarm/rest
          write_reg(uer_pkg::CFG_TRIGGER_TICKS,      18'd255);
          write_reg(uer_pkg::CFG_ECHO_TIMEOUT_TICKS, 18'd32767);
          write_reg(uer_pkg::CFG_ALARM_MIN_DIST,     18'd65535);
          write_reg(uer_pkg::CFG_ALARM_MAX_DIST,     18'd0);
          write_reg(uer_pkg::CFG_ALARM_TICKS,        18'd262143);
          write_reg(uer_pkg::CFG_REST_TICKS,         18'd262143);
        end
        1: begin
          // Bottom of every range that still measures
          write_reg(uer_pkg::CFG_TRIGGER_TICKS,      18'd1);
          write_reg(uer_pkg::CFG_ECHO_TIMEOUT_TICKS, 18'd1);
          write_reg(uer_pkg::CFG_ALARM_MIN_DIST,     18'd0);
          write_reg(uer_pkg::CFG_ALARM_MAX_DIST,     18'd65535);
          write_reg(uer_pkg::CFG_ALARM_TICKS,        18'd0);
          write_reg(uer_pkg::CFG_REST_TICKS,         18'd0);
        end
        default: begin
          tmo = $urandom_range(0, 40);
          lo  = $urandom_range(0, 50);
          write_reg(uer_pkg::CFG_TRIGGER_TICKS,
                    with_junk(uer_pkg::CFG_DATA_W'($urandom_range(0, 6)), 8));
          write_reg(uer_pkg::CFG_ECHO_TIMEOUT_TICKS,
                    with_junk(uer_pkg::CFG_DATA_W'(tmo), uer_pkg::WIDTH_W));
          write_reg(uer_pkg::CFG_ALARM_MIN_DIST,
                    with_junk(uer_pkg::CFG_DATA_W'(lo), uer_pkg::DIST_W));
          write_reg(uer_pkg::CFG_ALARM_MAX_DIST,
                    with_junk(uer_pkg::CFG_DATA_W'(lo + $urandom_range(0, 40)),
                              uer_pkg::DIST_W));
          write_reg(uer_pkg::CFG_ALARM_TICKS,
                    uer_pkg::CFG_DATA_W'($urandom_range(0, 8)));
          write_reg(uer_pkg::CFG_REST_TICKS,
                    uer_pkg::CFG_DATA_W'($urandom_range(0, 8)));
        end
      endcase
      // Run a few phases with no idling on either side
      quiet     = (p >= 4 && p <= 6);
      noise_pct = 4;
      repeat ((p == 0) ? 300 : 90) send_tick(next_echo(), 1'b0, '0);
    end

    // Drain, then wait out any stray word
    quiet    = 1'b0;
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Sent %0d ticks over %0d register settings.", ticks_sent, settings);
    $display("Saw %0d readings, %0d of them timed out, and %0d alarm ticks.",
             readings, timeouts, alarm_seen);
    if (errors == 0 && pending_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Stall the result side at random, about 15 percent of the time, except in the quiet stretch
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < 15);
  end

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Pop the oldest owed word for every accepted result word
  always @(posedge clk) begin : result_check
    uer_pkg::res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $error("result word with none owed");
        errors++;
      end else begin
        want = pending_words.pop_front();
        check_field("trigger_level", 32'(want.trigger_level), 32'(out_trigger_level));
        check_field("alarm_level",   32'(want.alarm_level),   32'(out_alarm_level));
        check_field("reading_ready", 32'(want.reading_ready), 32'(out_reading_ready));
        check_field("timed_out",     32'(want.timed_out),     32'(out_timed_out));
        check_field("distance",      32'(want.distance),      32'(out_distance));
      end
    end
  end

  // Watchdog: give up when no word moves on either side for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $error("no word moved for %0d cycles, %0d still owed", STALL_LIMIT,
               pending_words.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

endmodule

// ----- files.f -----
+incdir+src
src/uer_pkg.sv
src/uer_cfg_regs.sv
src/uer_fsm.sv
src/uer_out_buf.sv
src/ultrasonic_echo_ranger.sv
tb/testbench.sv
